[hw/rtl/ppt_pkg.sv]
`default_nettype none

package ppt_pkg;

	localparam int SLOTS_DEF      = 16;
	localparam int COLD_SPLIT_DEF = 21;
	localparam int PERM_COUNT_DEF = 42;

	localparam int KIND_W         = 3;
	localparam int PID_W          = 16;
	localparam int PERM_W         = 6;
	localparam int LEVEL_W        = 3;
	localparam int STATUS_W       = 2;
	localparam int KILL_W         = 42;
	localparam int LEVELS_PER_MAP = 21;
	localparam int MAP_W          = LEVELS_PER_MAP * LEVEL_W;
	localparam int LEVELS_W       = 2 * MAP_W;

	localparam logic [KIND_W-1:0] KIND_REGISTER   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_UNREGISTER = 3'd1;
	localparam logic [KIND_W-1:0] KIND_GRANT      = 3'd2;
	localparam logic [KIND_W-1:0] KIND_REVOKE     = 3'd3;
	localparam logic [KIND_W-1:0] KIND_CHECK      = 3'd4;
	localparam logic [KIND_W-1:0] KIND_HAS_MIN    = 3'd5;

	localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

	typedef logic [LEVEL_W-1:0] level_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [PID_W-1:0]  pid;
		logic [PERM_W-1:0] permission;
		level_t            level;
	} cmd_word_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		level_t              level_out;
		logic                meets_minimum;
		logic [PID_W-1:0]    new_pid;
	} rsp_word_t;

	typedef struct packed {
		level_t rd_level;
		logic   killed;
		logic   meets;
	} lvl_res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_ACT,
		ST_MODIFY,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

[hw/rtl/ppt_ram.sv]
`default_nettype none

module ppt_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  wire logic                                    clk,
	input  wire logic                                    we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                        wdata,
	input  wire logic                                    re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output      logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[hw/rtl/ppt_level_unit.sv]
`default_nettype none

module ppt_level_unit #(
	parameter int COLD_SPLIT = ppt_pkg::COLD_SPLIT_DEF,
	parameter int PERM_COUNT = ppt_pkg::PERM_COUNT_DEF
) (
	input  wire logic [ppt_pkg::LEVELS_W-1:0] levels,
	input  wire logic [ppt_pkg::PERM_W-1:0]   permission,
	input  wire ppt_pkg::level_t              level,
	input  wire ppt_pkg::level_t              wr_level,
	input  wire logic [ppt_pkg::KILL_W-1:0]   kill_mask,
	output      logic [ppt_pkg::LEVELS_W-1:0] new_levels,
	output      ppt_pkg::lvl_res_t            res
);

	localparam int PW = ppt_pkg::PERM_W;
	localparam int MW = ppt_pkg::MAP_W;
	localparam int LW = ppt_pkg::LEVEL_W;

	logic                  perm_ok;
	logic                  cold;
	logic                  in_range;
	logic [PW-1:0]         idx;
	logic [MW-1:0]         map;
	logic [MW-1:0]         new_map;
	ppt_pkg::level_t       rd;
	logic                  killed;

	always_comb begin
		perm_ok  = permission < PW'(PERM_COUNT);
		cold     = permission >= PW'(COLD_SPLIT);
		idx      = cold ? (permission - PW'(COLD_SPLIT)) : permission;
		in_range = perm_ok && (idx < PW'(ppt_pkg::LEVELS_PER_MAP));
		map      = cold ? levels[2*MW-1:MW] : levels[MW-1:0];
		rd       = '0;
		new_map  = map;
		for (int j = 0; j < ppt_pkg::LEVELS_PER_MAP; j++) begin
			if (in_range && (idx == PW'(j))) begin
				rd                    = map[j*LW +: LW];
				new_map[j*LW +: LW]   = wr_level;
			end
		end
		new_levels = cold ? {new_map, levels[MW-1:0]} : {levels[2*MW-1:MW], new_map};
		killed = 1'b0;
		for (int j = 0; j < ppt_pkg::KILL_W; j++) begin
			killed = killed | (perm_ok && (permission == PW'(j)) && kill_mask[j]);
		end
		res.rd_level = rd;
		res.killed   = killed;
		res.meets    = rd >= level;
	end

endmodule

`default_nettype wire

[hw/rtl/process_permission_table.sv]
// An accepted word of a defined kind searches the id memory one slot per cycle, and the search ends
// at the slot that holds the id or at the last slot.
// The block takes one word at a time and stalls new words until the response is out.
// Grant, revoke, check and has-minimum on a found id read the level memory in ST_ACT;
// grant and revoke write the new levels back in ST_MODIFY.
// Reset clears all slot valid bits, the id counter and the kill mask at once.
`default_nettype none

module process_permission_table #(
	parameter int SLOTS      = ppt_pkg::SLOTS_DEF,
	parameter int COLD_SPLIT = ppt_pkg::COLD_SPLIT_DEF,
	parameter int PERM_COUNT = ppt_pkg::PERM_COUNT_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cmd_valid,
	output      logic                       cmd_stall,
	input  wire ppt_pkg::cmd_word_t         cmd,
	output      logic                       rsp_valid,
	input  wire logic                       rsp_stall,
	output      ppt_pkg::rsp_word_t         rsp,
	input  wire logic                       cfg_valid,
	output      logic                       cfg_ready,
	input  wire logic [ppt_pkg::KILL_W-1:0] cfg_data
);

	localparam int SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW  = $clog2(SLOTS + 1);
	localparam int PDW = ppt_pkg::PID_W;
	localparam int LVW = ppt_pkg::LEVELS_W;

	ppt_pkg::state_t        state_q, state_d;
	ppt_pkg::cmd_word_t     cmd_q;
	ppt_pkg::rsp_word_t     res_q, res_d, rsp_q;
	logic                   res_load;
	logic                   rsp_valid_q;
	logic [SLOTS-1:0]       valid_q;
	logic [PDW-1:0]         next_pid_q;
	logic [ppt_pkg::KILL_W-1:0] kill_q;
	logic [CW-1:0]          scan_q;
	logic                   issued_s1;
	logic [SW-1:0]          idx_s1;
	logic                   hit_q;
	logic [SW-1:0]          slot_q;
	logic                   free_vld_q;
	logic [SW-1:0]          free_q;

	logic                   accept;
	logic                   rsp_free;
	logic                   to_rsp;
	logic [PDW-1:0]         key;
	logic                   cmp_hit;
	logic                   cmp_free;
	logic                   cmp_last;
	logic                   search_done;
	logic                   issue;
	logic                   is_register;
	logic                   is_level_op;
	logic [SW-1:0]          act_slot;
	logic                   valid_set;
	logic                   valid_clr;
	logic                   bump_pid;

	logic                   pid_we;
	logic [PDW-1:0]         pid_rdata;
	logic                   lvl_we;
	logic                   lvl_re;
	logic [LVW-1:0]         lvl_wdata;
	logic [LVW-1:0]         lvl_rdata;
	logic [LVW-1:0]         lvl_new;
	ppt_pkg::level_t        wr_level;
	ppt_pkg::lvl_res_t      lvl_res;

	ppt_ram #(
		.WIDTH(PDW),
		.DEPTH(SLOTS)
	) u_pid_ram (
		.clk  (clk),
		.we   (pid_we),
		.waddr(act_slot),
		.wdata(next_pid_q),
		.re   (issue),
		.raddr(scan_q[SW-1:0]),
		.rdata(pid_rdata)
	);

	ppt_ram #(
		.WIDTH(LVW),
		.DEPTH(SLOTS)
	) u_level_ram (
		.clk  (clk),
		.we   (lvl_we),
		.waddr(act_slot),
		.wdata(lvl_wdata),
		.re   (lvl_re),
		.raddr(slot_q),
		.rdata(lvl_rdata)
	);

	assign wr_level = (cmd_q.kind == ppt_pkg::KIND_REVOKE) ? '0 : cmd_q.level;

	ppt_level_unit #(
		.COLD_SPLIT(COLD_SPLIT),
		.PERM_COUNT(PERM_COUNT)
	) u_level_unit (
		.levels    (lvl_rdata),
		.permission(cmd_q.permission),
		.level     (cmd_q.level),
		.wr_level  (wr_level),
		.kill_mask (kill_q),
		.new_levels(lvl_new),
		.res       (lvl_res)
	);

	assign cmd_stall = state_q != ppt_pkg::ST_IDLE;
	assign accept    = cmd_valid && !cmd_stall;
	assign cfg_ready = 1'b1;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign is_register = cmd_q.kind == ppt_pkg::KIND_REGISTER;
	assign is_level_op = (cmd_q.kind == ppt_pkg::KIND_GRANT) ||
		(cmd_q.kind == ppt_pkg::KIND_REVOKE) || (cmd_q.kind == ppt_pkg::KIND_CHECK) ||
		(cmd_q.kind == ppt_pkg::KIND_HAS_MIN);
	assign act_slot = (is_register && !hit_q) ? free_q : slot_q;

	// The id read issued for one slot returns in the next cycle, where it is compared.
	assign key         = is_register ? next_pid_q : cmd_q.pid;
	assign cmp_hit     = issued_s1 && valid_q[idx_s1] && (pid_rdata == key);
	assign cmp_free    = issued_s1 && !valid_q[idx_s1];
	assign cmp_last    = issued_s1 && (idx_s1 == SW'(SLOTS - 1));
	assign search_done = cmp_hit || cmp_last;
	assign issue       = (state_q == ppt_pkg::ST_SEARCH) && (scan_q < CW'(SLOTS)) &&
		!search_done;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ppt_pkg::ST_IDLE: begin
				if (cmd_valid) begin
					state_d = (cmd.kind > ppt_pkg::KIND_HAS_MIN) ? ppt_pkg::ST_DONE
						: ppt_pkg::ST_SEARCH;
				end
			end
			ppt_pkg::ST_SEARCH: begin
				if (search_done) begin
					state_d = ppt_pkg::ST_ACT;
				end
			end
			ppt_pkg::ST_ACT: begin
				state_d = (hit_q && is_level_op) ? ppt_pkg::ST_MODIFY : ppt_pkg::ST_DONE;
			end
			ppt_pkg::ST_MODIFY: begin
				state_d = ppt_pkg::ST_DONE;
			end
			ppt_pkg::ST_DONE: begin
				if (rsp_free) begin
					state_d = ppt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ppt_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		res_load  = 1'b0;
		res_d     = '0;
		pid_we    = 1'b0;
		lvl_we    = 1'b0;
		lvl_re    = 1'b0;
		lvl_wdata = '0;
		valid_set = 1'b0;
		valid_clr = 1'b0;
		bump_pid  = 1'b0;
		to_rsp    = 1'b0;
		unique case (state_q)
			ppt_pkg::ST_IDLE: begin
				res_load = accept;
			end
			ppt_pkg::ST_SEARCH: begin
			end
			ppt_pkg::ST_ACT: begin
				if (is_register) begin
					res_load = 1'b1;
					if (hit_q || free_vld_q) begin
						pid_we        = 1'b1;
						lvl_we        = 1'b1;
						valid_set     = 1'b1;
						bump_pid      = 1'b1;
						res_d.new_pid = next_pid_q;
					end else begin
						res_d.status = ppt_pkg::STATUS_FULL;
					end
				end else if (!hit_q) begin
					res_load     = 1'b1;
					res_d.status = ppt_pkg::STATUS_NOT_FOUND;
				end else if (cmd_q.kind == ppt_pkg::KIND_UNREGISTER) begin
					valid_clr = 1'b1;
				end else begin
					lvl_re = 1'b1;
				end
			end
			ppt_pkg::ST_MODIFY: begin
				res_load  = 1'b1;
				lvl_wdata = lvl_new;
				if ((cmd_q.kind == ppt_pkg::KIND_GRANT) ||
					(cmd_q.kind == ppt_pkg::KIND_REVOKE)) begin
					lvl_we = 1'b1;
				end else if (cmd_q.kind == ppt_pkg::KIND_CHECK) begin
					res_d.level_out = lvl_res.killed ? '0 : lvl_res.rd_level;
				end else begin
					res_d.meets_minimum = lvl_res.meets;
				end
			end
			ppt_pkg::ST_DONE: begin
				to_rsp = rsp_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ppt_pkg::ST_IDLE;
			valid_q     <= '0;
			next_pid_q  <= '0;
			kill_q      <= '0;
			scan_q      <= '0;
			issued_s1   <= 1'b0;
			hit_q       <= 1'b0;
			free_vld_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			issued_s1 <= issue;
			if (cfg_valid && cfg_ready) begin
				kill_q <= cfg_data;
			end
			if (accept) begin
				scan_q     <= '0;
				hit_q      <= 1'b0;
				free_vld_q <= 1'b0;
			end else if (state_q == ppt_pkg::ST_SEARCH) begin
				if (issue) begin
					scan_q <= scan_q + CW'(1);
				end
				if (cmp_hit) begin
					hit_q <= 1'b1;
				end
				if (cmp_free) begin
					free_vld_q <= 1'b1;
				end
			end
			if (valid_set) begin
				valid_q[act_slot] <= 1'b1;
			end
			if (valid_clr) begin
				valid_q[slot_q] <= 1'b0;
			end
			if (bump_pid) begin
				next_pid_q <= next_pid_q + PDW'(1);
			end
			if (to_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
		end
		idx_s1 <= scan_q[SW-1:0];
		if ((state_q == ppt_pkg::ST_SEARCH) && cmp_hit) begin
			slot_q <= idx_s1;
		end
		if ((state_q == ppt_pkg::ST_SEARCH) && cmp_free && !free_vld_q) begin
			free_q <= idx_s1;
		end
		if (res_load) begin
			res_q <= res_d;
		end
		if (to_rsp) begin
			rsp_q <= res_q;
		end
	end

endmodule

`default_nettype wire

[dv/process_permission_table_test.sv]
module process_permission_table_test;
	timeunit 1ns;
	timeprecision 1ps;

	import ppt_pkg::*;

	localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
	localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	cmd_word_t cmd;
	logic rsp_valid;
	logic rsp_stall;
	rsp_word_t rsp;
	logic cfg_valid;
	logic cfg_ready;
	logic [KILL_W-1:0] cfg_data;

	process_permission_table u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	bit slot_used [SLOTS_DEF];
	logic [PID_W-1:0] slot_id [SLOTS_DEF];
	logic [MAP_W-1:0] map_hot [SLOTS_DEF];
	logic [MAP_W-1:0] map_cold [SLOTS_DEF];
	logic [PID_W-1:0] pid_counter = '0;
	logic [KILL_W-1:0] kill_bits = '0;

	rsp_word_t pending_rsps [$];
	int error_count = 0;
	int cmd_count = 0;
	int rsp_count = 0;
	int full_count = 0;
	int reuse_count = 0;
	int masked_count = 0;
	int mask_writes = 0;
	bit sender_idle_en = 0;
	bit rsp_idle_en = 0;
	int rsp_hold_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("process_permission_table_test failed");
		$finish;
	end

	function automatic int slot_of(logic [PID_W-1:0] id);
		for (int i = 0; i < SLOTS_DEF; i++)
			if (slot_used[i] && slot_id[i] == id)
				return i;
		return -1;
	endfunction

	function automatic bit place_perm(input logic [PERM_W-1:0] p, output bit cold,
			output int unsigned idx);
		cold = p >= COLD_SPLIT_DEF;
		idx = cold ? p - COLD_SPLIT_DEF : p;
		return p < PERM_COUNT_DEF && idx < LEVELS_PER_MAP;
	endfunction

	function automatic level_t stored_level(int s, logic [PERM_W-1:0] p);
		bit cold;
		int unsigned idx;
		if (!place_perm(p, cold, idx))
			return '0;
		return cold ? map_cold[s][idx*LEVEL_W +: LEVEL_W]
			: map_hot[s][idx*LEVEL_W +: LEVEL_W];
	endfunction

	function automatic void put_level(int s, logic [PERM_W-1:0] p, level_t lvl);
		bit cold;
		int unsigned idx;
		if (place_perm(p, cold, idx)) begin
			if (cold)
				map_cold[s][idx*LEVEL_W +: LEVEL_W] = lvl;
			else
				map_hot[s][idx*LEVEL_W +: LEVEL_W] = lvl;
		end
	endfunction

	// Applies one command word to the table copy and returns the response it should give.
	function automatic rsp_word_t run_table_op(cmd_word_t c);
		rsp_word_t r;
		int s;
		r = '0;
		case (c.kind)
			KIND_REGISTER: begin
				s = slot_of(pid_counter);
				if (s >= 0)
					reuse_count++;
				for (int i = 0; i < SLOTS_DEF && s < 0; i++)
					if (!slot_used[i])
						s = i;
				if (s < 0) begin
					r.status = STATUS_FULL;
					full_count++;
				end else begin
					slot_used[s] = 1'b1;
					slot_id[s] = pid_counter;
					map_hot[s] = '0;
					map_cold[s] = '0;
					r.new_pid = pid_counter;
					pid_counter = pid_counter + 1'b1;
				end
			end
			KIND_UNREGISTER, KIND_GRANT, KIND_REVOKE, KIND_CHECK, KIND_HAS_MIN: begin
				s = slot_of(c.pid);
				if (s < 0)
					r.status = STATUS_NOT_FOUND;
				else
					case (c.kind)
						KIND_UNREGISTER: slot_used[s] = 1'b0;
						KIND_GRANT: put_level(s, c.permission, c.level);
						KIND_REVOKE: put_level(s, c.permission, '0);
						KIND_CHECK: begin
							if (c.permission < PERM_COUNT_DEF && kill_bits[c.permission])
								masked_count++;
							else
								r.level_out = stored_level(s, c.permission);
						end
						default: r.meets_minimum = stored_level(s, c.permission) >= c.level;
					endcase
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic cmd_word_t cmd_of(logic [KIND_W-1:0] k, logic [PID_W-1:0] p,
			logic [PERM_W-1:0] pm, level_t l);
		cmd_word_t c;
		c.kind = k;
		c.pid = p;
		c.permission = pm;
		c.level = l;
		return c;
	endfunction

	function automatic logic [PERM_W-1:0] boundary_perm(int unsigned i);
		case (i)
			0: return '0;
			1: return PERM_W'(COLD_SPLIT_DEF - 1);
			2: return PERM_W'(COLD_SPLIT_DEF);
			3: return PERM_W'(PERM_COUNT_DEF - 1);
			4: return PERM_W'(PERM_COUNT_DEF);
			default: return '1;
		endcase
	endfunction

	function automatic logic [PID_W-1:0] pick_pid();
		logic [PID_W-1:0] live [$];
		int roll;
		roll = $urandom_range(0, 99);
		foreach (slot_used[i])
			if (slot_used[i])
				live.push_back(slot_id[i]);
		if (roll < 75 && live.size() > 0)
			return live[$urandom_range(0, live.size() - 1)];
		if (roll < 88)
			return PID_W'(pid_counter - $urandom_range(0, 3));
		return PID_W'($urandom);
	endfunction

	function automatic cmd_word_t random_cmd();
		cmd_word_t c;
		int roll;
		c.pid = pick_pid();
		c.level = level_t'($urandom_range(0, 7));
		roll = $urandom_range(0, 99);
		if (roll < 80)
			c.permission = PERM_W'($urandom_range(0, PERM_COUNT_DEF - 1));
		else if (roll < 90)
			c.permission = boundary_perm($urandom_range(0, 3));
		else
			c.permission = PERM_W'($urandom_range(PERM_COUNT_DEF, 63));
		roll = $urandom_range(0, 99);
		if (roll < 11)
			c.kind = KIND_REGISTER;
		else if (roll < 20)
			c.kind = KIND_UNREGISTER;
		else if (roll < 45)
			c.kind = KIND_GRANT;
		else if (roll < 55)
			c.kind = KIND_REVOKE;
		else if (roll < 75)
			c.kind = KIND_CHECK;
		else if (roll < 95)
			c.kind = KIND_HAS_MIN;
		else
			c.kind = $urandom_range(0, 1) ? KIND_SPARE_HI : KIND_SPARE_LO;
		return c;
	endfunction

	task automatic send_cmd(cmd_word_t c);
		if (sender_idle_en && $urandom_range(0, 3) == 0) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		pending_rsps.push_back(run_table_op(c));
		cmd_count++;
	endtask

	task automatic wait_all_results();
		cmd_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending_rsps.size() != 0);
		@(posedge clk);
	endtask

	task automatic write_kill_mask(logic [KILL_W-1:0] m);
		cfg_valid <= 1'b1;
		cfg_data <= m;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		kill_bits = m;
		mask_writes++;
	endtask

	task automatic test_directed_ops();
		send_cmd(cmd_of(KIND_CHECK, '0, '0, '0));
		send_cmd(cmd_of(KIND_UNREGISTER, '1, '1, '1));
		send_cmd(cmd_of(KIND_REGISTER, '1, '1, '1));
		send_cmd(cmd_of(KIND_REGISTER, '0, '0, '0));
		send_cmd(cmd_of(KIND_GRANT, 16'd0, boundary_perm(0), 3'd7));
		send_cmd(cmd_of(KIND_GRANT, 16'd0, boundary_perm(1), 3'd5));
		send_cmd(cmd_of(KIND_GRANT, 16'd0, boundary_perm(2), 3'd3));
		send_cmd(cmd_of(KIND_GRANT, 16'd0, boundary_perm(3), 3'd7));
		send_cmd(cmd_of(KIND_GRANT, 16'd0, boundary_perm(5), 3'd7));
		send_cmd(cmd_of(KIND_CHECK, 16'd0, boundary_perm(0), '0));
		send_cmd(cmd_of(KIND_CHECK, 16'd0, boundary_perm(3), '0));
		send_cmd(cmd_of(KIND_CHECK, 16'd0, boundary_perm(4), '0));
		send_cmd(cmd_of(KIND_HAS_MIN, 16'd0, boundary_perm(1), 3'd5));
		send_cmd(cmd_of(KIND_HAS_MIN, 16'd0, boundary_perm(1), 3'd6));
		send_cmd(cmd_of(KIND_HAS_MIN, 16'd0, boundary_perm(5), 3'd0));
		send_cmd(cmd_of(KIND_HAS_MIN, 16'd0, boundary_perm(2), 3'd7));
		send_cmd(cmd_of(KIND_REVOKE, 16'd0, boundary_perm(0), 3'd7));
		send_cmd(cmd_of(KIND_CHECK, 16'd0, boundary_perm(0), '0));
		send_cmd(cmd_of(KIND_SPARE_LO, 16'd0, '1, '1));
		send_cmd(cmd_of(KIND_SPARE_HI, '1, '0, '1));
		send_cmd(cmd_of(KIND_GRANT, '1, '1, '1));
		send_cmd(cmd_of(KIND_UNREGISTER, 16'd1, '0, '0));
		send_cmd(cmd_of(KIND_CHECK, 16'd1, '0, '0));
		send_cmd(cmd_of(KIND_HAS_MIN, 16'd1, '0, '0));
	endtask

	task automatic test_kill_mask();
		logic [PID_W-1:0] id;
		logic [KILL_W-1:0] m;
		id = pid_counter;
		send_cmd(cmd_of(KIND_REGISTER, '0, '0, '0));
		for (int i = 0; i < 6; i++)
			send_cmd(cmd_of(KIND_GRANT, id, boundary_perm(i), level_t'(i + 2)));
		for (int k = 0; k < 4; k++) begin
			case (k)
				0: m = {KILL_W{1'b1}};
				1: m = {(KILL_W/2){2'b10}};
				2: m = {(KILL_W/2){2'b01}};
				default: m = '0;
			endcase
			wait_all_results();
			write_kill_mask(m);
			for (int i = 0; i < 6; i++) begin
				send_cmd(cmd_of(KIND_CHECK, id, boundary_perm(i), '0));
				send_cmd(cmd_of(KIND_HAS_MIN, id, boundary_perm(i), level_t'(i + 2)));
			end
		end
	endtask

	task automatic test_table_full();
		repeat (SLOTS_DEF + 2)
			send_cmd(cmd_of(KIND_REGISTER, PID_W'($urandom), '0, '0));
		send_cmd(cmd_of(KIND_UNREGISTER, slot_id[SLOTS_DEF/2], '0, '0));
		send_cmd(cmd_of(KIND_REGISTER, '0, '0, '0));
		send_cmd(cmd_of(KIND_GRANT, slot_id[SLOTS_DEF/2], boundary_perm(3), 3'd4));
		send_cmd(cmd_of(KIND_CHECK, slot_id[SLOTS_DEF/2], boundary_perm(3), '0));
		send_cmd(cmd_of(KIND_REGISTER, '0, '0, '0));
	endtask

	task automatic test_random_traffic();
		for (int phase = 0; phase < 5; phase++) begin
			repeat (120)
				send_cmd(random_cmd());
			wait_all_results();
			if (phase == 2)
				write_kill_mask(KILL_W'(64'd1 << $urandom_range(0, KILL_W - 1)));
			else
				write_kill_mask(KILL_W'({$urandom, $urandom}));
		end
	endtask

	task automatic test_output_backpressure();
		sender_idle_en = 0;
		rsp_hold_cycles = 300;
		repeat (40)
			send_cmd(random_cmd());
		wait_all_results();
		sender_idle_en = 1;
	endtask

	// Empties the table and fills it again, then frees the lowest id so that the next
	// register takes that slot under a fresh id while the other slots keep their levels.
	task automatic test_slot_refill();
		logic [PID_W-1:0] base;
		wait_all_results();
		for (int i = 0; i < SLOTS_DEF; i++)
			if (slot_used[i])
				send_cmd(cmd_of(KIND_UNREGISTER, slot_id[i], '0, '0));
		base = pid_counter;
		repeat (SLOTS_DEF)
			send_cmd(cmd_of(KIND_REGISTER, '0, '0, '0));
		send_cmd(cmd_of(KIND_GRANT, base + 1'b1, 6'd5, 3'd6));
		send_cmd(cmd_of(KIND_GRANT, base + 1'b1, 6'd30, 3'd7));
		send_cmd(cmd_of(KIND_UNREGISTER, base, '0, '0));
		send_cmd(cmd_of(KIND_REGISTER, '0, '0, '0));
		send_cmd(cmd_of(KIND_CHECK, base + 1'b1, 6'd5, '0));
		send_cmd(cmd_of(KIND_HAS_MIN, base + 1'b1, 6'd30, 3'd1));
		send_cmd(cmd_of(KIND_REGISTER, '0, '0, '0));
		send_cmd(cmd_of(KIND_CHECK, base, 6'd5, '0));
	endtask

	initial begin : rsp_stall_gen
		int n;
		rsp_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_hold_cycles > 0) begin
				n = rsp_hold_cycles;
				rsp_hold_cycles = 0;
				rsp_stall <= 1'b1;
				repeat (n) @(posedge clk);
				rsp_stall <= 1'b0;
			end else if (rsp_idle_en && $urandom_range(0, 4) == 0) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				rsp_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : rsp_checker
		rsp_word_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			rsp_count++;
			if (pending_rsps.size() == 0) begin
				error_count++;
				$display("%0t: unexpected response %0d/%0d/%0b/%0d (status/level/meets/id)",
					$time, rsp.status, rsp.level_out, rsp.meets_minimum, rsp.new_pid);
			end else begin
				want = pending_rsps.pop_front();
				if (rsp !== want) begin
					error_count++;
					$display("%0t: expected %0d/%0d/%0b/%0d, got %0d/%0d/%0b/%0d (status/level/meets/id)",
						$time, want.status, want.level_out, want.meets_minimum, want.new_pid,
						rsp.status, rsp.level_out, rsp.meets_minimum, rsp.new_pid);
				end
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		cmd_valid <= 1'b0;
		cmd <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		sender_idle_en = 1;
		rsp_idle_en = 1;
		test_directed_ops();
		wait_all_results();
		test_kill_mask();
		test_table_full();
		test_random_traffic();
		test_output_backpressure();
		sender_idle_en = 0;
		rsp_idle_en = 0;
		test_slot_refill();
		wait_all_results();
		repeat (SLOTS_DEF + 8) @(posedge clk);
		$display("Sent %0d command words, checked %0d response words, wrote the kill mask %0d times.",
			cmd_count, rsp_count, mask_writes);
		$display("Saw %0d full-table registers, %0d registers onto a live id and %0d masked checks.",
			full_count, reuse_count, masked_count);
		if (error_count == 0)
			$display("process_permission_table_test passed");
		else
			$display("process_permission_table_test failed");
		$finish;
	end

endmodule
